// File: design/tgd_pkg.sv
// Shared types and constants of the trackball gesture detector.
// Used by the channel interfaces, the gesture engine and the top level.
package tgd_pkg;

   // Report modes.
   localparam logic [1:0] MODE_POINTER = 2'd0;
   localparam logic [1:0] MODE_SPACES  = 2'd1;
   localparam logic [1:0] MODE_PAGE    = 2'd2;
   localparam logic [1:0] MODE_FLICK   = 2'd3;

   // Gesture directions.
   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_LEFT  = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   // Gesture sets.
   localparam logic SET_SPACES = 1'b0;
   localparam logic SET_PAGE   = 1'b1;

   // Control register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRE_LEVEL            = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDLE_GAP_MS           = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COOLDOWN_MS           = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLICK_LEFT_THRESHOLD  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLICK_RIGHT_THRESHOLD = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLICK_WINDOW_MS       = 3'd5;

   // Control register reset values.
   localparam logic [14:0]        RST_FIRE_LEVEL            = 15'd50;
   localparam logic [15:0]        RST_IDLE_GAP_MS           = 16'd120;
   localparam logic [15:0]        RST_COOLDOWN_MS           = 16'd400;
   localparam logic signed [15:0] RST_FLICK_LEFT_THRESHOLD  = -16'sd25;
   localparam logic [14:0]        RST_FLICK_RIGHT_THRESHOLD = 15'd15;
   localparam logic [15:0]        RST_FLICK_WINDOW_MS       = 16'd200;

   // Pointer clipping limits.
   localparam logic signed [15:0] CLIP_HIGH = 16'sd127;
   localparam logic signed [15:0] CLIP_LOW  = -16'sd127;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] sensor_x;
      logic signed [15:0] sensor_y;
      logic               mirrored;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic              move_valid;
      logic signed [7:0] move_x;
      logic signed [7:0] move_y;
      logic              gesture_fire;
      logic              gesture_set;
      logic [1:0]        gesture_dir;
      logic              to_pointer_mode;
   } rsp_type;

   typedef struct packed {
      logic [14:0]        fire_level;
      logic [15:0]        idle_gap_ms;
      logic [15:0]        cooldown_ms;
      logic signed [15:0] flick_left_threshold;
      logic [14:0]        flick_right_threshold;
      logic [15:0]        flick_window_ms;
   } cfg_type;

endpackage

// File: design/tgd_if.sv
// Valid/ready channel interfaces for motion reports and detector results.
// Payload types come from tgd_pkg.
interface tgd_req_if;
   logic             valid;
   logic             ready;
   tgd_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tgd_rsp_if;
   logic             valid;
   logic             ready;
   tgd_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: design/tgd_engine.sv
// Gesture engine: holds the accumulator, timestamp and flick state and turns one
// registered motion report into one result combinationally. Uses tgd_pkg.
module tgd_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  tgd_pkg::req_type item,
   input  tgd_pkg::cfg_type cfg,
   output tgd_pkg::rsp_type result
);

   logic signed [16:0] accum_h_ff, accum_h_in;
   logic signed [16:0] accum_v_ff, accum_v_in;
   logic [31:0]        last_motion_ff, last_motion_in;
   logic [31:0]        last_fire_ff, last_fire_in;
   logic               flick_armed_ff, flick_armed_in;
   logic [31:0]        flick_arm_time_ff, flick_arm_time_in;

   logic signed [16:0] sx_wide, sy_wide, horiz, vert;
   logic               motion;
   logic signed [7:0]  clip_x, clip_y;
   logic               idle_clear, in_cooldown;
   logic signed [16:0] sum_h, sum_v;
   logic [16:0]        mag_h, mag_v, thr_wide;
   logic               hit;
   logic [1:0]         dir;
   logic [31:0]        flick_age;
   logic               flick_left, flick_right, flick_in_window;

   always_comb begin
      sx_wide = 17'(item.sensor_x);
      sy_wide = 17'(item.sensor_y);
      horiz   = item.mirrored ? -sy_wide : sy_wide;
      vert    = item.mirrored ? -sx_wide : sx_wide;
      motion  = (item.sensor_x != '0) || (item.sensor_y != '0);

      // Pointer path: clip before the mirror negation.
      if (item.sensor_y > tgd_pkg::CLIP_HIGH) begin
         clip_x = 8'(tgd_pkg::CLIP_HIGH);
      end else if (item.sensor_y < tgd_pkg::CLIP_LOW) begin
         clip_x = 8'(tgd_pkg::CLIP_LOW);
      end else begin
         clip_x = item.sensor_y[7:0];
      end
      if (item.sensor_x > tgd_pkg::CLIP_HIGH) begin
         clip_y = 8'(tgd_pkg::CLIP_HIGH);
      end else if (item.sensor_x < tgd_pkg::CLIP_LOW) begin
         clip_y = 8'(tgd_pkg::CLIP_LOW);
      end else begin
         clip_y = item.sensor_x[7:0];
      end
      if (item.mirrored) begin
         clip_x = -clip_x;
         clip_y = -clip_y;
      end

      // Gesture path. Time differences wrap modulo 2^32.
      idle_clear  = (item.now_ms - last_motion_ff) > {16'd0, cfg.idle_gap_ms};
      in_cooldown = (item.now_ms - last_fire_ff) <= {16'd0, cfg.cooldown_ms};
      sum_h = (idle_clear ? 17'sd0 : accum_h_ff) + horiz;
      sum_v = (idle_clear ? 17'sd0 : accum_v_ff) + vert;
      mag_h = sum_h[16] ? 17'(-sum_h) : 17'(sum_h);
      mag_v = sum_v[16] ? 17'(-sum_v) : 17'(sum_v);
      thr_wide = {2'd0, cfg.fire_level};
      hit = (mag_h >= thr_wide) || (mag_v >= thr_wide);
      if (mag_h >= mag_v) begin
         dir = (sum_h > 17'sd0) ? tgd_pkg::DIR_RIGHT : tgd_pkg::DIR_LEFT;
      end else begin
         dir = (sum_v > 17'sd0) ? tgd_pkg::DIR_DOWN : tgd_pkg::DIR_UP;
      end

      // Flick path.
      flick_age       = item.now_ms - flick_arm_time_ff;
      flick_in_window = flick_age <= {16'd0, cfg.flick_window_ms};
      flick_left      = horiz <= 17'(cfg.flick_left_threshold);
      flick_right     = horiz >= $signed({2'd0, cfg.flick_right_threshold});

      result            = '0;
      accum_h_in        = accum_h_ff;
      accum_v_in        = accum_v_ff;
      last_motion_in    = last_motion_ff;
      last_fire_in      = last_fire_ff;
      flick_armed_in    = flick_armed_ff;
      flick_arm_time_in = flick_arm_time_ff;

      unique case (item.mode)
         tgd_pkg::MODE_POINTER: begin
            result.move_valid = 1'b1;
            result.move_x     = clip_x;
            result.move_y     = clip_y;
            flick_armed_in    = 1'b0;
         end
         tgd_pkg::MODE_SPACES, tgd_pkg::MODE_PAGE: begin
            if (motion) begin
               last_motion_in = item.now_ms;
               if (in_cooldown || hit) begin
                  accum_h_in = '0;
                  accum_v_in = '0;
               end else begin
                  accum_h_in = sum_h;
                  accum_v_in = sum_v;
               end
               if (!in_cooldown && hit) begin
                  result.gesture_fire = 1'b1;
                  result.gesture_set  = (item.mode == tgd_pkg::MODE_PAGE) ?
                                        tgd_pkg::SET_PAGE : tgd_pkg::SET_SPACES;
                  result.gesture_dir  = dir;
                  last_fire_in        = item.now_ms;
               end
            end
         end
         tgd_pkg::MODE_FLICK: begin
            if (motion) begin
               priority if (flick_left) begin
                  flick_armed_in    = 1'b1;
                  flick_arm_time_in = item.now_ms;
               end else if (flick_armed_ff && flick_right) begin
                  result.to_pointer_mode = flick_in_window;
                  flick_armed_in         = 1'b0;
               end else if (flick_armed_ff && !flick_in_window) begin
                  flick_armed_in = 1'b0;
               end else begin
                  flick_armed_in = flick_armed_ff;
               end
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_h_ff        <= '0;
         accum_v_ff        <= '0;
         last_motion_ff    <= '0;
         last_fire_ff      <= '0;
         flick_armed_ff    <= 1'b0;
         flick_arm_time_ff <= '0;
      end else if (step_en) begin
         accum_h_ff        <= accum_h_in;
         accum_v_ff        <= accum_v_in;
         last_motion_ff    <= last_motion_in;
         last_fire_ff      <= last_fire_in;
         flick_armed_ff    <= flick_armed_in;
         flick_arm_time_ff <= flick_arm_time_in;
      end
   end

   // A fire always leaves both accumulators cleared.
   assert property (@(posedge clock) disable iff (reset)
      step_en && result.gesture_fire |=> accum_h_ff == '0 && accum_v_ff == '0)
      else $error("accumulators not cleared after a gesture fire");

   // The accumulators only change on a gesture report.
   assert property (@(posedge clock) disable iff (reset)
      step_en && item.mode != tgd_pkg::MODE_SPACES && item.mode != tgd_pkg::MODE_PAGE
      |=> $stable(accum_h_ff) && $stable(accum_v_ff))
      else $error("accumulators changed outside gesture mode");

   // A pointer report always leaves the flick detector disarmed.
   assert property (@(posedge clock) disable iff (reset)
      step_en && item.mode == tgd_pkg::MODE_POINTER |=> !flick_armed_ff)
      else $error("flick detector still armed after a pointer report");

endmodule

// File: design/trackball_gesture_detector_top.sv
// Top level of the trackball gesture detector: channel handshake, control
// registers and pipeline registers around tgd_engine. Uses tgd_pkg and tgd_if.
//
// The detector takes one motion report beat per clock on req_bus unless the
// result consumer holds it back, and returns exactly one result beat per
// report on rsp_bus, in order. A report is first captured in an input register;
// when the output register is empty or being drained, the engine computes its
// result and updates the gesture state in a single step, and the result is
// captured in the output register, from which it is offered on rsp_bus. The
// sustained rate is one report per cycle, set by the state update loop in the
// engine while the consumer keeps up, and a new report is taken while a finished
// result still waits for the consumer. Pointer mode (0) passes the swapped axes
// through, clipped to plus or minus 127 and negated when mirrored. The gesture
// modes (1 spaces, 2 page) accumulate motion and fire a direction once either
// accumulated magnitude reaches the threshold; flick mode (3) requests the
// pointer layer after a left flick followed by a right one within the window.
// Control registers are written through csr_we, csr_index and csr_wdata and
// should only be changed while no report is in flight; writes to unused indexes
// are ignored.
module trackball_gesture_detector_top (
   input  logic                                   clock,
   input  logic                                   reset,
   tgd_req_if.sink                                req_bus,
   tgd_rsp_if.source                              rsp_bus,
   input  logic                                   csr_we,
   input  logic [tgd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [tgd_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   tgd_pkg::cfg_type cfg_ff, cfg_in;

   // Input stage.
   logic             in_valid_ff, in_valid_in;
   tgd_pkg::req_type in_item_ff;

   // Output stage.
   logic             rsp_valid_ff, rsp_valid_in;
   tgd_pkg::rsp_type rsp_payload_ff;
   tgd_pkg::rsp_type step_result;

   logic req_take;
   logic advance;

   // The captured report moves on when the output register is empty or its
   // beat is being taken in this same cycle.
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;

   assign req_bus.ready   = !in_valid_ff || advance;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            tgd_pkg::CSR_FIRE_LEVEL:            cfg_in.fire_level = csr_wdata[14:0];
            tgd_pkg::CSR_IDLE_GAP_MS:           cfg_in.idle_gap_ms = csr_wdata;
            tgd_pkg::CSR_COOLDOWN_MS:           cfg_in.cooldown_ms = csr_wdata;
            tgd_pkg::CSR_FLICK_LEFT_THRESHOLD:  cfg_in.flick_left_threshold = csr_wdata;
            tgd_pkg::CSR_FLICK_RIGHT_THRESHOLD: cfg_in.flick_right_threshold = csr_wdata[14:0];
            tgd_pkg::CSR_FLICK_WINDOW_MS:       cfg_in.flick_window_ms = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fire_level            <= tgd_pkg::RST_FIRE_LEVEL;
         cfg_ff.idle_gap_ms           <= tgd_pkg::RST_IDLE_GAP_MS;
         cfg_ff.cooldown_ms           <= tgd_pkg::RST_COOLDOWN_MS;
         cfg_ff.flick_left_threshold  <= tgd_pkg::RST_FLICK_LEFT_THRESHOLD;
         cfg_ff.flick_right_threshold <= tgd_pkg::RST_FLICK_RIGHT_THRESHOLD;
         cfg_ff.flick_window_ms       <= tgd_pkg::RST_FLICK_WINDOW_MS;
         in_valid_ff                  <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_bus.payload;
      end
      if (advance) begin
         rsp_payload_ff <= step_result;
      end
   end

   tgd_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   // A result describes at most one kind of event.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.gesture_fire
      |-> !rsp_payload_ff.move_valid && !rsp_payload_ff.to_pointer_mode)
      else $error("gesture fire mixed with another event");

   // Without a fire the gesture fields stay zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.gesture_fire
      |-> rsp_payload_ff.gesture_dir == tgd_pkg::DIR_RIGHT
          && rsp_payload_ff.gesture_set == tgd_pkg::SET_SPACES)
      else $error("gesture fields set without a fire");

   // Pointer motion never leaves the clipping range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.move_valid |-> rsp_payload_ff.move_x != 8'sh80
          && rsp_payload_ff.move_y != 8'sh80)
      else $error("pointer motion outside the clipping range");

   // Every report that advances shows up as a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced report produced no result");

endmodule

// File: test/tb_trackball_gesture_detector_top.sv
// Self-checking testbench for trackball_gesture_detector_top: directed and random
// motion reports checked beat by beat against a behavioral predictor.
// Depends on tgd_pkg, the tgd_req_if/tgd_rsp_if interfaces and the detector RTL.
module tb_trackball_gesture_detector_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Clock, reset and the three ports of the block.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                                csr_we;
   logic [tgd_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [tgd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   tgd_req_if req_bus ();
   tgd_rsp_if rsp_bus ();

   trackball_gesture_detector_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Reports waiting to be offered, and the results the predictor says must come
   // back, oldest first. The block answers every report with exactly one beat.
   tgd_pkg::req_type queued_reports[$];
   tgd_pkg::rsp_type awaited_results[$];

   // Predictor copy of the control registers and of the gesture state.
   tgd_pkg::cfg_type detector_cfg;
   int               accum_h;
   int               accum_v;
   logic [31:0]      last_motion_ms;
   logic [31:0]      last_fire_ms;
   logic             flick_armed;
   logic [31:0]      flick_arm_ms;

   // Idle percentages of the two sides, the long receiver hold-off, and the
   // running timestamp used when building reports.
   int          send_idle_pct;
   int          recv_idle_pct;
   logic        rx_hold_start;
   int          rx_hold_left;
   logic [31:0] stim_ms;

   int failures;
   int reports_sent;
   int results_checked;
   int fires_seen;
   int flicks_seen;
   int moves_seen;
   int settings_applied;

   function automatic int clip_move(input int v);
      if (v < int'(tgd_pkg::CLIP_LOW)) return int'(tgd_pkg::CLIP_LOW);
      if (v > int'(tgd_pkg::CLIP_HIGH)) return int'(tgd_pkg::CLIP_HIGH);
      return v;
   endfunction

   // Computes the result of one report and advances the gesture and flick state.
   // All time differences are taken modulo 2^32, as unsigned 32 bit values.
   function automatic tgd_pkg::rsp_type detector_result(input tgd_pkg::req_type rpt);
      int               sx;
      int               sy;
      int               horiz;
      int               vert;
      int               mx;
      int               my;
      int               mag_h;
      int               mag_v;
      logic             motion;
      logic [31:0]      age;
      tgd_pkg::rsp_type res;
      sx = int'(rpt.sensor_x);
      sy = int'(rpt.sensor_y);
      motion = (sx != 0) || (sy != 0);
      horiz = rpt.mirrored ? -sy : sy;
      vert = rpt.mirrored ? -sx : sx;
      res = '0;
      if (rpt.mode == tgd_pkg::MODE_POINTER) begin
         // The axes swap, are clipped first and only then negated.
         mx = clip_move(sy);
         my = clip_move(sx);
         if (rpt.mirrored) begin
            mx = -mx;
            my = -my;
         end
         res.move_valid = 1'b1;
         res.move_x = mx[7:0];
         res.move_y = my[7:0];
         flick_armed = 1'b0;
      end else if (rpt.mode == tgd_pkg::MODE_SPACES || rpt.mode == tgd_pkg::MODE_PAGE) begin
         if (motion) begin
            age = rpt.now_ms - last_motion_ms;
            if (age > 32'(detector_cfg.idle_gap_ms)) begin
               accum_h = 0;
               accum_v = 0;
            end
            last_motion_ms = rpt.now_ms;
            age = rpt.now_ms - last_fire_ms;
            if (age <= 32'(detector_cfg.cooldown_ms)) begin
               accum_h = 0;
               accum_v = 0;
            end else begin
               accum_h += horiz;
               accum_v += vert;
               mag_h = (accum_h < 0) ? -accum_h : accum_h;
               mag_v = (accum_v < 0) ? -accum_v : accum_v;
               if (mag_h >= int'(detector_cfg.fire_level) ||
                   mag_v >= int'(detector_cfg.fire_level)) begin
                  res.gesture_fire = 1'b1;
                  res.gesture_set = (rpt.mode == tgd_pkg::MODE_PAGE) ?
                                    tgd_pkg::SET_PAGE : tgd_pkg::SET_SPACES;
                  // Ties go to the horizontal axis.
                  if (mag_h >= mag_v)
                     res.gesture_dir = (accum_h > 0) ? tgd_pkg::DIR_RIGHT : tgd_pkg::DIR_LEFT;
                  else
                     res.gesture_dir = (accum_v > 0) ? tgd_pkg::DIR_DOWN : tgd_pkg::DIR_UP;
                  accum_h = 0;
                  accum_v = 0;
                  last_fire_ms = rpt.now_ms;
               end
            end
         end
      end else if (motion) begin
         age = rpt.now_ms - flick_arm_ms;
         if (horiz <= int'(detector_cfg.flick_left_threshold)) begin
            flick_armed = 1'b1;
            flick_arm_ms = rpt.now_ms;
         end else if (flick_armed && horiz >= int'(detector_cfg.flick_right_threshold)) begin
            res.to_pointer_mode = (age <= 32'(detector_cfg.flick_window_ms));
            flick_armed = 1'b0;
         end else if (flick_armed && age > 32'(detector_cfg.flick_window_ms)) begin
            flick_armed = 1'b0;
         end
      end
      return res;
   endfunction

   // Driver: offers the oldest queued report and keeps valid high until the beat
   // is taken. The expected result is worked out at the edge that accepts it.
   always @(posedge clock) begin : report_driver
      logic next_valid;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         next_valid = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            awaited_results.push_back(detector_result(req_bus.payload));
            void'(queued_reports.pop_front());
            reports_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid && queued_reports.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            next_valid = 1'b1;
            req_bus.payload <= queued_reports[0];
         end
         req_bus.valid <= next_valid;
      end
   end

   // Long receiver hold-off, counted here so the monitor only has to look at it.
   always @(posedge clock) begin
      if (reset)
         rx_hold_left <= 0;
      else if (rx_hold_start)
         rx_hold_left <= 300;
      else if (rx_hold_left != 0)
         rx_hold_left <= rx_hold_left - 1;
   end

   // Monitor: every accepted result beat is matched against the oldest awaited one.
   always @(posedge clock) begin : result_monitor
      tgd_pkg::rsp_type want;
      tgd_pkg::rsp_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.payload;
            if (awaited_results.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: result beat with nothing awaited: mv=%0b x=%0d y=%0d",
                           $realtime, got.move_valid, got.move_x, got.move_y);
            end else begin
               want = awaited_results.pop_front();
               results_checked++;
               if (got.move_valid !== want.move_valid || got.move_x !== want.move_x ||
                   got.move_y !== want.move_y || got.gesture_fire !== want.gesture_fire ||
                   got.gesture_set !== want.gesture_set ||
                   got.gesture_dir !== want.gesture_dir ||
                   got.to_pointer_mode !== want.to_pointer_mode) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("%0t: result %0d differs: expected mv=%0b x=%0d y=%0d fire=%0b set=%0b dir=%0d ptr=%0b",
                              $realtime, results_checked, want.move_valid, want.move_x,
                              want.move_y, want.gesture_fire, want.gesture_set,
                              want.gesture_dir, want.to_pointer_mode);
                     $display("   got mv=%0b x=%0d y=%0d fire=%0b set=%0b dir=%0d ptr=%0b",
                              got.move_valid, got.move_x, got.move_y, got.gesture_fire,
                              got.gesture_set, got.gesture_dir, got.to_pointer_mode);
                  end
               end
               if (want.gesture_fire) fires_seen++;
               if (want.to_pointer_mode) flicks_seen++;
               if (want.move_valid) moves_seen++;
            end
         end
         rsp_bus.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Register write: one cycle with the enable high. The predictor copy follows
   // at once, which is safe because writes only happen while nothing is in flight.
   task automatic write_reg(input logic [tgd_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      unique case (idx)
         tgd_pkg::CSR_FIRE_LEVEL:            detector_cfg.fire_level = val[14:0];
         tgd_pkg::CSR_IDLE_GAP_MS:           detector_cfg.idle_gap_ms = val;
         tgd_pkg::CSR_COOLDOWN_MS:           detector_cfg.cooldown_ms = val;
         tgd_pkg::CSR_FLICK_LEFT_THRESHOLD:  detector_cfg.flick_left_threshold = val;
         tgd_pkg::CSR_FLICK_RIGHT_THRESHOLD: detector_cfg.flick_right_threshold = val[14:0];
         tgd_pkg::CSR_FLICK_WINDOW_MS:       detector_cfg.flick_window_ms = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Holds the sender back until every awaited result has come, then lets the
   // pipeline settle.
   task automatic wait_for_idle();
      while (queued_reports.size() != 0 || awaited_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void queue_report(input logic [1:0] m, input int sx, input int sy,
                                        input logic mir, input logic [31:0] at_ms);
      tgd_pkg::req_type rpt;
      rpt.mode = m;
      rpt.sensor_x = sx[15:0];
      rpt.sensor_y = sy[15:0];
      rpt.mirrored = mir;
      rpt.now_ms = at_ms;
      queued_reports.push_back(rpt);
   endfunction

   function automatic int pick_axis(input int span);
      int mag;
      if ($urandom_range(99) < 15) return 0;
      mag = $urandom_range(span);
      return $urandom_range(1) ? mag : -mag;
   endfunction

   function automatic int clamp_count(input int v);
      if (v > 32767) return 32767;
      if (v < -32767) return -32767;
      return v;
   endfunction

   // Random reports come in runs of one mode with a mostly creeping timestamp, so
   // that gestures build up, cool down and time out, and flicks alternate between
   // arming and completing near the current thresholds. A small share is noise:
   // stray modes, no motion, raw 16 bit counts, full-scale counts, time jumps.
   task automatic queue_random_reports(input int count);
      int               run_left;
      int               h;
      int               v;
      int               r;
      int               k;
      logic [1:0]       run_mode;
      tgd_pkg::req_type rpt;
      run_left = 0;
      run_mode = tgd_pkg::MODE_POINTER;
      for (k = 0; k < count; k++) begin
         if (run_left == 0) begin
            run_mode = 2'($urandom_range(3));
            run_left = $urandom_range(14, 3);
         end
         run_left--;
         r = $urandom_range(99);
         if (r < 70)
            stim_ms += $urandom_range(80);
         else if (r < 90)
            stim_ms += $urandom_range(600, 80);
         else if (r < 97)
            stim_ms += $urandom_range(70000);
         else
            stim_ms = $urandom;
         rpt.mode = ($urandom_range(19) == 0) ? 2'($urandom_range(3)) : run_mode;
         rpt.mirrored = 1'($urandom_range(1));
         rpt.now_ms = stim_ms;
         unique case (rpt.mode)
            tgd_pkg::MODE_POINTER: begin
               h = pick_axis(200);
               v = pick_axis(200);
            end
            tgd_pkg::MODE_FLICK: begin
               if ($urandom_range(4) == 0)
                  h = pick_axis(60);
               else if (k % 2 == 0)
                  h = int'(detector_cfg.flick_left_threshold) + int'($urandom_range(6)) - 4;
               else
                  h = int'(detector_cfg.flick_right_threshold) + int'($urandom_range(6)) - 2;
               v = pick_axis(10);
            end
            default: begin
               h = pick_axis(int'(detector_cfg.fire_level) + 4);
               v = pick_axis(int'(detector_cfg.fire_level) + 4);
            end
         endcase
         h = clamp_count(h);
         v = clamp_count(v);
         // The axes are swapped and negated when mirrored, so build the raw counts
         // that give the intended horizontal and vertical motion.
         rpt.sensor_y = 16'(rpt.mirrored ? -h : h);
         rpt.sensor_x = 16'(rpt.mirrored ? -v : v);
         r = $urandom_range(99);
         if (r < 8) begin
            rpt.sensor_x = '0;
            rpt.sensor_y = '0;
         end else if (r < 14) begin
            rpt.sensor_x = 16'($urandom);
            rpt.sensor_y = 16'($urandom);
         end else if (r < 17) begin
            rpt.sensor_x = 16'h8000;
         end else if (r < 20) begin
            rpt.sensor_y = 16'h8000;
         end
         queued_reports.push_back(rpt);
      end
   endtask

   // Register settings per phase: the reset values, all lows, all highs, and
   // moderate random values that keep gestures and flicks firing.
   task automatic apply_setting(input int ph);
      logic [15:0] th;
      logic [15:0] gap;
      logic [15:0] cool;
      logic [15:0] lt;
      logic [15:0] rt;
      logic [15:0] win;
      unique case (ph)
         0: begin
            th = 16'(tgd_pkg::RST_FIRE_LEVEL);
            gap = tgd_pkg::RST_IDLE_GAP_MS;
            cool = tgd_pkg::RST_COOLDOWN_MS;
            lt = tgd_pkg::RST_FLICK_LEFT_THRESHOLD;
            rt = 16'(tgd_pkg::RST_FLICK_RIGHT_THRESHOLD);
            win = tgd_pkg::RST_FLICK_WINDOW_MS;
         end
         1: begin
            th = 16'd1;
            gap = 16'd0;
            cool = 16'd0;
            lt = 16'd0;
            rt = 16'd0;
            win = 16'd0;
         end
         2: begin
            th = 16'd32767;
            gap = 16'd65535;
            cool = 16'd65535;
            lt = 16'h8001;
            rt = 16'd32767;
            win = 16'd65535;
         end
         default: begin
            th = 16'($urandom_range(120, 1));
            gap = 16'($urandom_range(400));
            cool = 16'($urandom_range(700));
            lt = 16'(-int'($urandom_range(90)));
            rt = 16'($urandom_range(90));
            win = 16'($urandom_range(500));
         end
      endcase
      write_reg(tgd_pkg::CSR_FIRE_LEVEL, th);
      write_reg(tgd_pkg::CSR_IDLE_GAP_MS, gap);
      write_reg(tgd_pkg::CSR_COOLDOWN_MS, cool);
      write_reg(tgd_pkg::CSR_FLICK_LEFT_THRESHOLD, lt);
      write_reg(tgd_pkg::CSR_FLICK_RIGHT_THRESHOLD, rt);
      write_reg(tgd_pkg::CSR_FLICK_WINDOW_MS, win);
      settings_applied++;
   endtask

   // Hard stop in case the block hangs or drops a result.
   initial begin
      #5_000_000;
      $display("trackball_gesture_detector_top regression: fail");
      $finish;
   end

   initial begin : sequencer
      int ph;
      // Every input of the block is known from time zero.
      csr_we = 1'b0;
      csr_index = tgd_pkg::CSR_FIRE_LEVEL;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      rx_hold_start = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stim_ms = 32'd10000;
      failures = 0;
      reports_sent = 0;
      results_checked = 0;
      fires_seen = 0;
      flicks_seen = 0;
      moves_seen = 0;
      settings_applied = 0;

      // The predictor starts from the reset state of the block.
      detector_cfg.fire_level = tgd_pkg::RST_FIRE_LEVEL;
      detector_cfg.idle_gap_ms = tgd_pkg::RST_IDLE_GAP_MS;
      detector_cfg.cooldown_ms = tgd_pkg::RST_COOLDOWN_MS;
      detector_cfg.flick_left_threshold = tgd_pkg::RST_FLICK_LEFT_THRESHOLD;
      detector_cfg.flick_right_threshold = tgd_pkg::RST_FLICK_RIGHT_THRESHOLD;
      detector_cfg.flick_window_ms = tgd_pkg::RST_FLICK_WINDOW_MS;
      accum_h = 0;
      accum_v = 0;
      last_motion_ms = '0;
      last_fire_ms = '0;
      flick_armed = 1'b0;
      flick_arm_ms = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct <= 36;
      recv_idle_pct <= 55;

      // Pointer mode: a zero move still reports, full-scale counts clip, and a
      // mirrored -32768 is negated after clipping.
      queue_report(tgd_pkg::MODE_POINTER, 0, 0, 1'b0, 32'd10);
      queue_report(tgd_pkg::MODE_POINTER, 32767, -32768, 1'b0, 32'd20);
      queue_report(tgd_pkg::MODE_POINTER, -32768, 100, 1'b1, 32'd30);
      // Right after reset the last fire counts as time zero, so this is swallowed.
      queue_report(tgd_pkg::MODE_SPACES, 0, 60, 1'b0, 32'd100);
      // Two reports add up to a right fire; the next one falls in the cooldown.
      queue_report(tgd_pkg::MODE_SPACES, 0, 30, 1'b0, 32'd1000);
      queue_report(tgd_pkg::MODE_SPACES, 0, 30, 1'b0, 32'd1050);
      queue_report(tgd_pkg::MODE_SPACES, 0, 80, 1'b0, 32'd1200);
      // Page set, vertical wins: up.
      queue_report(tgd_pkg::MODE_PAGE, -60, 0, 1'b0, 32'd1500);
      // Equal axes: the tie goes horizontal. The zero report in between is ignored.
      queue_report(tgd_pkg::MODE_SPACES, 40, 40, 1'b0, 32'd2000);
      queue_report(tgd_pkg::MODE_SPACES, 0, 0, 1'b0, 32'd2010);
      queue_report(tgd_pkg::MODE_SPACES, 10, 10, 1'b0, 32'd2050);
      // Mirrored gesture turns right into left.
      queue_report(tgd_pkg::MODE_PAGE, 0, 60, 1'b1, 32'd2600);
      // A pause longer than the idle gap throws away the earlier motion.
      queue_report(tgd_pkg::MODE_SPACES, 0, 40, 1'b0, 32'd3100);
      queue_report(tgd_pkg::MODE_SPACES, 0, 40, 1'b0, 32'd3300);
      // Mirrored full-scale count accumulates as +32768: down.
      queue_report(tgd_pkg::MODE_SPACES, -32768, 0, 1'b1, 32'd3400);
      // Fire just below the wrap, then a report past the wrap still in cooldown.
      queue_report(tgd_pkg::MODE_SPACES, 0, 60, 1'b0, 32'hFFFF_FFF0);
      queue_report(tgd_pkg::MODE_SPACES, 0, -60, 1'b0, 32'h0000_0100);
      // Flick: arm, ignore no motion, complete in time.
      queue_report(tgd_pkg::MODE_FLICK, 0, -30, 1'b0, 32'd5000);
      queue_report(tgd_pkg::MODE_FLICK, 0, 0, 1'b0, 32'd5050);
      queue_report(tgd_pkg::MODE_FLICK, 0, 20, 1'b0, 32'd5100);
      // Mirrored arm, then a pointer report disarms before the completion.
      queue_report(tgd_pkg::MODE_FLICK, 0, 30, 1'b1, 32'd6000);
      queue_report(tgd_pkg::MODE_POINTER, 1, 1, 1'b0, 32'd6010);
      queue_report(tgd_pkg::MODE_FLICK, 0, 20, 1'b0, 32'd6020);
      // Arm exactly at the threshold; a late completion only disarms.
      queue_report(tgd_pkg::MODE_FLICK, 0, -25, 1'b0, 32'd7000);
      queue_report(tgd_pkg::MODE_FLICK, 0, 15, 1'b0, 32'd7300);
      // Armed and expired: plain motion disarms.
      queue_report(tgd_pkg::MODE_FLICK, 0, -40, 1'b0, 32'd8000);
      queue_report(tgd_pkg::MODE_FLICK, 5, 0, 1'b0, 32'd8300);
      wait_for_idle();

      // With a zero threshold every report outside the cooldown fires.
      write_reg(tgd_pkg::CSR_FIRE_LEVEL, 16'd0);
      queue_report(tgd_pkg::MODE_SPACES, 0, 1, 1'b0, 32'd20000);
      queue_report(tgd_pkg::MODE_PAGE, 3, 0, 1'b0, 32'd20500);
      wait_for_idle();

      // Random phases. The first third idles the sender less than the receiver,
      // the second third the other way round, the last third not at all.
      for (ph = 0; ph < 12; ph++) begin
         if (ph < 4) begin
            send_idle_pct <= 36;
            recv_idle_pct <= 55;
         end else if (ph < 8) begin
            send_idle_pct <= 55;
            recv_idle_pct <= 36;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         apply_setting(ph);
         queue_random_reports(155);
         if (ph == 8) begin
            // The receiver stalls for a long stretch while reports keep coming,
            // so the block fills and pushes back on its input.
            rx_hold_start <= 1'b1;
            @(posedge clock);
            rx_hold_start <= 1'b0;
         end
         wait_for_idle();
      end

      repeat (8) @(posedge clock);
      failures += awaited_results.size();
      $display("Checked %0d results for %0d reports under %0d register settings:",
               results_checked, reports_sent, settings_applied + 1);
      $display("  %0d pointer moves, %0d gesture fires, %0d flick completions.",
               moves_seen, fires_seen, flicks_seen);
      if (failures == 0)
         $display("trackball_gesture_detector_top regression: pass");
      else
         $display("trackball_gesture_detector_top regression: fail");
      $finish;
   end

endmodule
